@@ hdl/motor_mode_controller_assert.svh @@
// Assertion macros for the motor mode controller.
// Included by the top level; needs nothing else.
`ifndef MOTOR_MODE_CONTROLLER_ASSERT_SVH
`define MOTOR_MODE_CONTROLLER_ASSERT_SVH

// Same-cycle implication: post must hold whenever pre holds.
`define MMC_ASSERT_IMP(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication: post must hold in the cycle after pre.
`define MMC_ASSERT_NXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/mmc_pkg.sv @@
// Shared types, codes and microcode table for the motor mode controller.
// No dependencies; used by the interfaces and the top level.
package mmc_pkg;

  localparam int DELTA_W = 16;
  localparam int TICK_W  = 32;
  localparam int POS_W   = 32;
  localparam int DUTY_W  = 8;
  localparam int GAIN_W  = 16;
  localparam int MODE_W  = 3;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 32;
  localparam int STEP_W  = 4;

  localparam logic [MODE_W-1:0] MODE_FLOAT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BRAKE    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MANUAL   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POSITION = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SPEED    = 3'd4;

  localparam logic [1:0] DRIVE_COAST = 2'd0;
  localparam logic [1:0] DRIVE_BRAKE = 2'd1;
  localparam logic [1:0] DRIVE_PWM   = 2'd2;

  localparam logic [IDX_W-1:0] REG_CONTROL_MODE     = 3'd0;
  localparam logic [IDX_W-1:0] REG_MANUAL_DIRECTION = 3'd1;
  localparam logic [IDX_W-1:0] REG_PWM_SETTING      = 3'd2;
  localparam logic [IDX_W-1:0] REG_TARGET_POSITION  = 3'd3;
  localparam logic [IDX_W-1:0] REG_TARGET_SPEED     = 3'd4;
  localparam logic [IDX_W-1:0] REG_GAIN_P           = 3'd5;
  localparam logic [IDX_W-1:0] REG_GAIN_D           = 3'd6;

  localparam logic [DUTY_W-1:0] DUTY_MAX  = 8'hff;
  localparam logic [POS_W-1:0]  SPEED_MAX = 32'h7fff_ffff;
  localparam logic [POS_W-1:0]  SPEED_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [DELTA_W-1:0] encoder_delta;
    logic [TICK_W-1:0]         tick_delta;
  } sample_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] speed;
    logic [DUTY_W-1:0]       pwm_duty;
    logic                    direction;
    logic [1:0]              drive_state;
  } result_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] value;
  } cfg_write_t;

  // Datapath operations selected by one control word.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_RATE,
    OP_DIV_SPEED,
    OP_SAT_SPEED,
    OP_DRIVE_FIXED,
    OP_MUL_POS,
    OP_MUL_D,
    OP_SUM_PD,
    OP_DRIVE_POS,
    OP_DIV_ERR,
    OP_DRIVE_SPEED,
    OP_EMIT
  } op_t;

  // Jump conditions; a miss falls through to the next step.
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_SAMPLE,
    COND_DIV_BUSY,
    COND_MODE_POS,
    COND_MODE_SPD,
    COND_OUT_FULL
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  localparam step_t S_IDLE       = 4'd0;
  localparam step_t S_MUL_RATE   = 4'd1;
  localparam step_t S_DIV_SPEED  = 4'd2;
  localparam step_t S_WAIT_SPEED = 4'd3;
  localparam step_t S_SAT_SPEED  = 4'd4;
  localparam step_t S_BRANCH_SPD = 4'd5;
  localparam step_t S_FIXED      = 4'd6;
  localparam step_t S_MUL_POS    = 4'd7;
  localparam step_t S_MUL_D      = 4'd8;
  localparam step_t S_SUM_PD     = 4'd9;
  localparam step_t S_DRIVE_POS  = 4'd10;
  localparam step_t S_DIV_ERR    = 4'd11;
  localparam step_t S_WAIT_ERR   = 4'd12;
  localparam step_t S_DRIVE_SPD  = 4'd13;
  localparam step_t S_EMIT       = 4'd14;
  localparam step_t S_DONE       = 4'd15;

  function automatic ucode_t ucode_rom(step_t step);
    ucode_t w;
    w = '{op: OP_NONE, cond: COND_ALWAYS, target: S_IDLE};
    unique case (step)
      S_IDLE:       w = '{op: OP_LOAD,        cond: COND_NO_SAMPLE, target: S_IDLE};
      S_MUL_RATE:   w = '{op: OP_MUL_RATE,    cond: COND_NEXT,      target: S_IDLE};
      S_DIV_SPEED:  w = '{op: OP_DIV_SPEED,   cond: COND_NEXT,      target: S_IDLE};
      S_WAIT_SPEED: w = '{op: OP_NONE,        cond: COND_DIV_BUSY,  target: S_WAIT_SPEED};
      S_SAT_SPEED:  w = '{op: OP_SAT_SPEED,   cond: COND_MODE_POS,  target: S_MUL_POS};
      S_BRANCH_SPD: w = '{op: OP_NONE,        cond: COND_MODE_SPD,  target: S_DIV_ERR};
      S_FIXED:      w = '{op: OP_DRIVE_FIXED, cond: COND_ALWAYS,    target: S_EMIT};
      S_MUL_POS:    w = '{op: OP_MUL_POS,     cond: COND_NEXT,      target: S_IDLE};
      S_MUL_D:      w = '{op: OP_MUL_D,       cond: COND_NEXT,      target: S_IDLE};
      S_SUM_PD:     w = '{op: OP_SUM_PD,      cond: COND_NEXT,      target: S_IDLE};
      S_DRIVE_POS:  w = '{op: OP_DRIVE_POS,   cond: COND_ALWAYS,    target: S_EMIT};
      S_DIV_ERR:    w = '{op: OP_DIV_ERR,     cond: COND_NEXT,      target: S_IDLE};
      S_WAIT_ERR:   w = '{op: OP_NONE,        cond: COND_DIV_BUSY,  target: S_WAIT_ERR};
      S_DRIVE_SPD:  w = '{op: OP_DRIVE_SPEED, cond: COND_NEXT,      target: S_IDLE};
      S_EMIT:       w = '{op: OP_EMIT,        cond: COND_OUT_FULL,  target: S_EMIT};
      S_DONE:       w = '{op: OP_NONE,        cond: COND_ALWAYS,    target: S_IDLE};
      default:      w = '{op: OP_NONE,        cond: COND_ALWAYS,    target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ hdl/mmc_if.sv @@
// Valid/ready channel interfaces for the motor mode controller.
// Payload types come from mmc_pkg.
interface mmc_sample_if import mmc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mmc_result_if import mmc_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mmc_cfg_if import mmc_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_write_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/mmc_divider.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
// Standalone; used by the motor mode controller for speed and error division.
module mmc_divider #(
  parameter int DVD_W = 32,
  parameter int DVS_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] count;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic [DVS_W:0]   rem_shift;
  logic [DVS_W:0]   rem_diff;

  always_comb begin
    rem_shift = {rem, quo[DVD_W-1]};
    rem_diff  = rem_shift - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(DVD_W);
    end else if (count != '0) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (count != '0) begin
      // No borrow: the shifted remainder covers the divisor.
      if (!rem_diff[DVS_W]) begin
        rem <= rem_diff[DVS_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DVS_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign busy     = (count != '0);
  assign quotient = quo;

endmodule

@@ hdl/motor_mode_controller.sv @@
// Motor mode controller: one result per sample, DVD_W = max(32, 15 + clog2(TICK_RATE + 1)).
// A sample is taken only in the idle step, once the previous one is done; the shared
// bit-serial divider does speed division in every mode and error division in speed mode.
// The result is loaded before the next sample is taken; reset also clears its valid flag.
// Synchronous active-high reset clears the config, position, held duty and the sequencer.
`include "motor_mode_controller_assert.svh"

module motor_mode_controller import mmc_pkg::*; #(
  parameter int TICK_RATE = 10000
) (
  input  logic         clk,
  input  logic         rst,
  mmc_cfg_if.sink      cfg,
  mmc_sample_if.sink   sample,
  mmc_result_if.source result
);

  // Derived widths; several follow from the tick rate.
  localparam int RATE_W  = $clog2(TICK_RATE + 1);
  localparam int ERR_W   = POS_W + 1;
  localparam int MUL_B_W = (RATE_W + 1 > ERR_W) ? RATE_W + 1 : ERR_W;
  localparam int PROD_W  = GAIN_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int MAG_W   = DELTA_W - 1 + RATE_W;
  localparam int DVD_W   = (MAG_W > POS_W) ? MAG_W : POS_W;
  localparam int DVS_W   = TICK_W;
  localparam int QS_W    = POS_W + 2;
  localparam int GPM_W   = GAIN_W + 1;

  // Configuration registers.
  logic [MODE_W-1:0]        control_mode;
  logic                     manual_direction;
  logic [DUTY_W-1:0]        pwm_setting;
  logic signed [POS_W-1:0]  target_position;
  logic signed [POS_W-1:0]  target_speed;
  logic signed [GAIN_W-1:0] gain_p;
  logic signed [GAIN_W-1:0] gain_d;

  // Sequencer.
  step_t  step;
  step_t  step_next;
  ucode_t uword;
  logic   cond_hit;

  // Datapath registers.
  logic signed [DELTA_W-1:0] delta;
  logic [TICK_W-1:0]         elapsed;
  logic signed [POS_W-1:0]   position_count;
  logic [DUTY_W-1:0]         held_duty;
  logic signed [PROD_W-1:0]  mul_prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [POS_W-1:0]   speed;
  logic                      quo_neg;
  logic [DUTY_W-1:0]         duty;
  logic                      dir;
  logic [1:0]                drive;

  // Result register.
  logic    out_valid;
  result_t out_data;

  // Combinational datapath.
  logic                      sample_fire;
  logic                      out_full;
  logic signed [GAIN_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      spd_neg;
  logic [PROD_W-1:0]         prod_mag;
  logic signed [ERR_W-1:0]   ts_ext;
  logic signed [ERR_W-1:0]   spd_ext;
  logic signed [ERR_W-1:0]   ts_mag;
  logic signed [ERR_W-1:0]   spd_mag;
  logic signed [ERR_W-1:0]   err;
  logic [ERR_W-1:0]          err_mag;
  logic signed [GPM_W-1:0]   gp_ext;
  logic [GPM_W-1:0]          gp_mag;
  logic                      div_start;
  logic                      div_busy;
  logic [DVD_W-1:0]          div_dividend;
  logic [DVS_W-1:0]          div_divisor;
  logic [DVD_W-1:0]          div_quotient;
  logic [POS_W-1:0]          speed_sat;
  logic                      raw_neg;
  logic [ACC_W-1:0]          raw_mag;
  logic [DUTY_W-1:0]         pos_duty;
  logic signed [QS_W-1:0]    q_ext;
  logic signed [QS_W-1:0]    q_signed;
  logic signed [QS_W-1:0]    spd_sum;
  logic [DUTY_W-1:0]         spd_duty;

  // Configuration writes are always taken; an index past the list is dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_mode     <= MODE_FLOAT;
      manual_direction <= 1'b0;
      pwm_setting      <= '0;
      target_position  <= '0;
      target_speed     <= '0;
      gain_p           <= '0;
      gain_d           <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_CONTROL_MODE:     control_mode     <= cfg.data.value[MODE_W-1:0];
        REG_MANUAL_DIRECTION: manual_direction <= cfg.data.value[0];
        REG_PWM_SETTING:      pwm_setting      <= cfg.data.value[DUTY_W-1:0];
        REG_TARGET_POSITION:  target_position  <= signed'(cfg.data.value[POS_W-1:0]);
        REG_TARGET_SPEED:     target_speed     <= signed'(cfg.data.value[POS_W-1:0]);
        REG_GAIN_P:           gain_p           <= signed'(cfg.data.value[GAIN_W-1:0]);
        REG_GAIN_D:           gain_d           <= signed'(cfg.data.value[GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  // Sequencer: fetch the control word for this step, take the jump on a hit,
  // otherwise advance to the next step.
  assign uword       = ucode_rom(step);
  assign sample.ready = (step == S_IDLE);
  assign sample_fire = sample.valid & sample.ready;
  assign out_full    = out_valid & ~result.ready;

  always_comb begin
    unique case (uword.cond)
      COND_NEXT:      cond_hit = 1'b0;
      COND_ALWAYS:    cond_hit = 1'b1;
      COND_NO_SAMPLE: cond_hit = ~sample.valid;
      COND_DIV_BUSY:  cond_hit = div_busy;
      COND_MODE_POS:  cond_hit = (control_mode == MODE_POSITION);
      COND_MODE_SPD:  cond_hit = (control_mode == MODE_SPEED);
      COND_OUT_FULL:  cond_hit = out_full;
      default:        cond_hit = 1'b0;
    endcase
    step_next = cond_hit ? uword.target : step + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Shared multiplier operands: delta times rate, then the two PD terms.
  always_comb begin
    case (uword.op)
      OP_MUL_RATE: begin
        mul_a = delta;
        mul_b = MUL_B_W'(TICK_RATE);
      end
      OP_MUL_POS: begin
        mul_a = gain_p;
        mul_b = MUL_B_W'(position_count) - MUL_B_W'(target_position);
      end
      OP_MUL_D: begin
        mul_a = gain_d;
        mul_b = MUL_B_W'(speed);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Speed: divide |delta * rate| by the elapsed ticks, restore the sign.
  assign spd_neg  = mul_prod[PROD_W-1];
  assign prod_mag = spd_neg ? PROD_W'(-mul_prod) : PROD_W'(mul_prod);

  // Speed-mode error: |target| - |speed|, divided by |gain_p|.
  assign ts_ext  = ERR_W'(target_speed);
  assign spd_ext = ERR_W'(speed);
  assign ts_mag  = ts_ext[ERR_W-1] ? -ts_ext : ts_ext;
  assign spd_mag = spd_ext[ERR_W-1] ? -spd_ext : spd_ext;
  assign err     = ts_mag - spd_mag;
  assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign gp_ext  = GPM_W'(gain_p);
  assign gp_mag  = gp_ext[GPM_W-1] ? GPM_W'(-gp_ext) : GPM_W'(gp_ext);

  assign div_start    = (uword.op == OP_DIV_SPEED) | (uword.op == OP_DIV_ERR);
  assign div_dividend = (uword.op == OP_DIV_ERR) ? DVD_W'(err_mag) : DVD_W'(prod_mag);
  assign div_divisor  = (uword.op == OP_DIV_ERR) ? DVS_W'(gp_mag) : elapsed;

  mmc_divider #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  // Saturate the signed speed to 32 bits.
  always_comb begin
    if (spd_neg) begin
      speed_sat = (div_quotient > DVD_W'(SPEED_MIN)) ? SPEED_MIN
                : ~div_quotient[POS_W-1:0] + POS_W'(1);
    end else begin
      speed_sat = (div_quotient > DVD_W'(SPEED_MAX)) ? SPEED_MAX
                : div_quotient[POS_W-1:0];
    end
  end

  // Position duty: magnitude of the PD sum, capped at full scale and pwm_setting.
  always_comb begin
    raw_neg  = acc[ACC_W-1];
    raw_mag  = raw_neg ? ACC_W'(-acc) : ACC_W'(acc);
    pos_duty = (raw_mag > ACC_W'(DUTY_MAX)) ? DUTY_MAX : raw_mag[DUTY_W-1:0];
    if (pos_duty > pwm_setting) begin
      pos_duty = pwm_setting;
    end
  end

  // Speed duty: held duty plus signed quotient, clamped to 0..255; zero gain_p holds it.
  always_comb begin
    q_ext    = QS_W'(div_quotient);
    q_signed = quo_neg ? -q_ext : q_ext;
    spd_sum  = QS_W'(held_duty) + q_signed;
    if (gain_p == '0) begin
      spd_duty = held_duty;
    end else if (spd_sum[QS_W-1]) begin
      spd_duty = '0;
    end else if (spd_sum > QS_W'(DUTY_MAX)) begin
      spd_duty = DUTY_MAX;
    end else begin
      spd_duty = spd_sum[DUTY_W-1:0];
    end
  end

  // Control state that carries from one sample to the next.
  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      held_duty      <= '0;
    end else begin
      case (uword.op)
        OP_LOAD: begin
          if (sample_fire) begin
            position_count <= position_count + POS_W'(sample.data.encoder_delta);
          end
        end
        OP_DRIVE_FIXED: begin
          if (control_mode == MODE_MANUAL) begin
            held_duty <= pwm_setting;
          end
        end
        OP_DRIVE_POS:   held_duty <= pos_duty;
        OP_DRIVE_SPEED: held_duty <= spd_duty;
        default: ;
      endcase
    end
  end

  // Working registers driven by the control word.
  always_ff @(posedge clk) begin
    case (uword.op)
      OP_LOAD: begin
        if (sample_fire) begin
          delta   <= sample.data.encoder_delta;
          // Elapsed zero counts as one tick.
          elapsed <= (sample.data.tick_delta == '0) ? TICK_W'(1) : sample.data.tick_delta;
        end
      end
      OP_MUL_RATE, OP_MUL_POS: begin
        mul_prod <= mul_a * mul_b;
      end
      OP_MUL_D: begin
        acc      <= ACC_W'(mul_prod);
        mul_prod <= mul_a * mul_b;
      end
      OP_SUM_PD: begin
        acc <= acc + ACC_W'(mul_prod);
      end
      OP_SAT_SPEED: begin
        speed <= signed'(speed_sat);
      end
      OP_DIV_ERR: begin
        quo_neg <= err[ERR_W-1] ^ gain_p[GAIN_W-1];
      end
      OP_DRIVE_FIXED: begin
        if (control_mode == MODE_MANUAL) begin
          duty  <= pwm_setting;
          dir   <= manual_direction;
          drive <= DRIVE_PWM;
        end else begin
          // Brake, float and unused codes drive zero duty, forward.
          duty  <= '0;
          dir   <= 1'b0;
          drive <= (control_mode == MODE_BRAKE) ? DRIVE_BRAKE : DRIVE_COAST;
        end
      end
      OP_DRIVE_POS: begin
        duty  <= pos_duty;
        dir   <= ~raw_neg & (acc != '0);
        drive <= DRIVE_PWM;
      end
      OP_DRIVE_SPEED: begin
        duty  <= spd_duty;
        dir   <= manual_direction;
        drive <= DRIVE_PWM;
      end
      default: ;
    endcase
  end

  // Result register: load at the emit step once the previous result is gone,
  // hold until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uword.op == OP_EMIT && !out_full) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uword.op == OP_EMIT && !out_full) begin
      out_data.position    <= position_count;
      out_data.speed       <= speed;
      out_data.pwm_duty    <= duty;
      out_data.direction   <= dir;
      out_data.drive_state <= drive;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

  // Checks on the sequencer and datapath.
  `MMC_ASSERT_NXT(a_div_start_busy, clk, rst, div_start, div_busy, "divider did not start")
  `MMC_ASSERT_NXT(a_sample_leaves_idle, clk, rst, sample_fire, step == S_MUL_RATE, "sequencer stuck after sample")
  `MMC_ASSERT_IMP(a_idle_divider, clk, rst, sample.ready, !div_busy, "divider busy while idle")
  `MMC_ASSERT_IMP(a_undriven_zero, clk, rst, result.valid && (result.data.drive_state != DRIVE_PWM), (result.data.pwm_duty == '0) && !result.data.direction, "nonzero duty without pwm drive")

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for motor_mode_controller: a directed table, then random phases.
// Depends on mmc_pkg, the mmc_*_if channel interfaces and the controller RTL under hdl.
module tb_top;
  import mmc_pkg::*;

  localparam int TICK_RATE   = 10000;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_TICKS = 600;
  // Idle time at the end; it outlasts the longest pass through the sequencer (speed mode).
  localparam int SETTLE_CYCLES = 80;

  // Register index 7 and mode codes 5 to 7 decode to nothing.
  localparam logic [IDX_W-1:0]  REG_UNUSED     = 3'd7;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  // One row of the directed table: a register write, or a tick with an optional
  // hand-computed result.
  typedef struct packed {
    bit                        is_write;
    logic [IDX_W-1:0]          idx;
    logic [CFG_W-1:0]          value;
    logic signed [DELTA_W-1:0] delta;
    logic [TICK_W-1:0]         ticks;
    bit                        pinned;
    result_t                   want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  mmc_cfg_if    cfg_ch ();
  mmc_sample_if sample_ch ();
  mmc_result_if result_ch ();

  motor_mode_controller #(.TICK_RATE(TICK_RATE)) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .sample(sample_ch),
    .result(result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the controller: register file, position counter and held duty.
  logic [MODE_W-1:0]        mode_r;
  logic                     dir_r;
  logic [DUTY_W-1:0]        pwm_ceiling;
  logic signed [POS_W-1:0]  goal_pos;
  logic signed [POS_W-1:0]  goal_speed;
  logic signed [GAIN_W-1:0] kp;
  logic signed [GAIN_W-1:0] kd;
  logic [POS_W-1:0]         odometer;
  logic [DUTY_W-1:0]        kept_duty;

  result_t pending_results[$];
  bit      pin_on;
  result_t pin_want;
  bit      calm_tx;
  int      ticks_taken;
  int      writes_taken;
  int      mismatches;
  int      cycle_count;
  int      mode_hits[8];
  result_t got;
  result_t want;
  result_t fresh;

  // Advance the predictor by one control tick and return the result it implies.
  function automatic result_t next_drive_result(logic signed [DELTA_W-1:0] d,
                                                logic [TICK_W-1:0] t);
    result_t r;
    longint  span;
    longint  rate;
    longint  raw;
    longint  aim;
    longint  meas;
    span = (t == '0) ? 64'sd1 : longint'({32'd0, t});
    odometer = odometer + {{(POS_W-DELTA_W){d[DELTA_W-1]}}, d};
    rate = (longint'(d) * TICK_RATE) / span;
    if (rate > 64'sd2147483647) rate = 64'sd2147483647;
    if (rate < -64'sd2147483648) rate = -64'sd2147483648;
    r = '0;
    r.position = odometer;
    r.speed = rate[31:0];
    r.drive_state = DRIVE_COAST;
    case (mode_r)
      MODE_BRAKE: begin
        r.drive_state = DRIVE_BRAKE;
      end
      MODE_MANUAL: begin
        r.pwm_duty = pwm_ceiling;
        r.direction = dir_r;
        r.drive_state = DRIVE_PWM;
        kept_duty = r.pwm_duty;
      end
      MODE_POSITION: begin
        // PD term is exact in 64 bits; sign picks direction, magnitude is clamped twice.
        raw = longint'(kp) * (longint'($signed(odometer)) - longint'(goal_pos))
            + longint'(kd) * rate;
        r.direction = (raw > 0);
        if (raw < 0) raw = -raw;
        if (raw > longint'(DUTY_MAX)) raw = longint'(DUTY_MAX);
        if (raw > longint'(pwm_ceiling)) raw = longint'(pwm_ceiling);
        r.pwm_duty = raw[7:0];
        r.drive_state = DRIVE_PWM;
        kept_duty = r.pwm_duty;
      end
      MODE_SPEED: begin
        // Integrate the magnitude error into the held duty; zero gain freezes it.
        r.direction = dir_r;
        raw = longint'(kept_duty);
        if (kp != 0) begin
          aim = longint'(goal_speed);
          if (aim < 0) aim = -aim;
          meas = (rate < 0) ? -rate : rate;
          raw = raw + (aim - meas) / longint'(kp);
        end
        if (raw < 0) raw = 0;
        if (raw > longint'(DUTY_MAX)) raw = longint'(DUTY_MAX);
        r.pwm_duty = raw[7:0];
        r.drive_state = DRIVE_PWM;
        kept_duty = r.pwm_duty;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Gap length: mostly none or short, now and then a long one.
  function automatic int gap_draw();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Fill the bits above the register width with junk now and then; the block drops them.
  function automatic logic [CFG_W-1:0] with_junk(logic [CFG_W-1:0] v, int w);
    logic [CFG_W-1:0] keep;
    keep = (w >= CFG_W) ? '1 : ((32'd1 << w) - 32'd1);
    if ($urandom_range(0, 4) == 0) v = (v & keep) | ($urandom & ~keep);
    return v;
  endfunction

  function automatic plan_row_t cw(logic [IDX_W-1:0] i, logic [CFG_W-1:0] v);
    plan_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.idx = i;
    row.value = v;
    return row;
  endfunction

  function automatic plan_row_t tk(logic signed [DELTA_W-1:0] d, logic [TICK_W-1:0] t);
    plan_row_t row;
    row = '0;
    row.delta = d;
    row.ticks = t;
    return row;
  endfunction

  function automatic plan_row_t tk_exp(logic signed [DELTA_W-1:0] d, logic [TICK_W-1:0] t,
                                       int pos, int spd, int duty, logic dir,
                                       logic [1:0] drive);
    plan_row_t row;
    row = tk(d, t);
    row.pinned = 1'b1;
    row.want.position = pos;
    row.want.speed = spd;
    row.want.pwm_duty = duty[7:0];
    row.want.direction = dir;
    row.want.drive_state = drive;
    return row;
  endfunction

  // Present one tick after a random gap and hold it until the controller takes it.
  task automatic send_tick(input logic signed [DELTA_W-1:0] d, input logic [TICK_W-1:0] t,
                           input bit pinned, input result_t hand_want);
    int gap;
    int goal;
    gap = calm_tx ? 0 : gap_draw();
    repeat (gap) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data.encoder_delta <= d;
    sample_ch.data.tick_delta <= t;
    pin_on = pinned;
    pin_want = hand_want;
    goal = ticks_taken + 1;
    do @(negedge clk); while (ticks_taken < goal);
  endtask

  // Drop the tick valid and wait until every predicted result has come back.
  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // One register write transaction; drop valid afterward so writes never merge.
  task automatic write_reg(input logic [IDX_W-1:0] i, input logic [CFG_W-1:0] v);
    int goal;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data.index <= i;
    cfg_ch.data.value <= v;
    goal = writes_taken + 1;
    do @(negedge clk); while (writes_taken < goal);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Monitor: apply register writes to the predictor, check results against the
  // oldest expectation, and predict each accepted tick. Results are checked before
  // the tick of the same edge is queued, since a tick never answers in its own cycle.
  always @(posedge clk) begin
    if (rst) begin
      mode_r = MODE_FLOAT;
      dir_r = 1'b0;
      pwm_ceiling = '0;
      goal_pos = '0;
      goal_speed = '0;
      kp = '0;
      kd = '0;
      odometer = '0;
      kept_duty = '0;
      cycle_count = 0;
    end else if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      cycle_count++;
      if (cfg_ch.valid && cfg_ch.ready) begin
        writes_taken++;
        case (cfg_ch.data.index)
          REG_CONTROL_MODE:     mode_r = cfg_ch.data.value[MODE_W-1:0];
          REG_MANUAL_DIRECTION: dir_r = cfg_ch.data.value[0];
          REG_PWM_SETTING:      pwm_ceiling = cfg_ch.data.value[DUTY_W-1:0];
          REG_TARGET_POSITION:  goal_pos = cfg_ch.data.value;
          REG_TARGET_SPEED:     goal_speed = cfg_ch.data.value;
          REG_GAIN_P:           kp = cfg_ch.data.value[GAIN_W-1:0];
          REG_GAIN_D:           kd = cfg_ch.data.value[GAIN_W-1:0];
          default: begin
          end
        endcase
      end
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: position %0d", got.position);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, got.position);
            mismatches++;
          end
          if (got.speed !== want.speed) begin
            $error("speed: expected %0d, got %0d", want.speed, got.speed);
            mismatches++;
          end
          if (got.pwm_duty !== want.pwm_duty) begin
            $error("pwm_duty: expected %0d, got %0d", want.pwm_duty, got.pwm_duty);
            mismatches++;
          end
          if (got.direction !== want.direction) begin
            $error("direction: expected %0d, got %0d", want.direction, got.direction);
            mismatches++;
          end
          if (got.drive_state !== want.drive_state) begin
            $error("drive_state: expected %0d, got %0d", want.drive_state,
                   got.drive_state);
            mismatches++;
          end
        end
      end
      if (sample_ch.valid && sample_ch.ready) begin
        ticks_taken++;
        mode_hits[mode_r]++;
        fresh = next_drive_result(sample_ch.data.encoder_delta, sample_ch.data.tick_delta);
        // Rows with a hand-computed result are checked against that value instead.
        pending_results.push_back(pin_on ? pin_want : fresh);
      end
    end
  end

  // Result sink: random stalls, with calm stretches where ready stays high.
  initial begin
    int  hold;
    int  span;
    bit  calm_rx;
    hold = 0;
    span = 0;
    calm_rx = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        calm_rx = ($urandom_range(0, 3) == 0);
        span = $urandom_range(50, 400);
      end
      span--;
      if (hold > 0) begin
        result_ch.ready <= 1'b0;
        hold--;
      end else begin
        result_ch.ready <= 1'b1;
        if (!calm_rx && $urandom_range(0, 99) < 30) hold = gap_draw();
      end
    end
  end

  // Stimulus: directed table first, then random phases with fresh register settings.
  initial begin
    plan_row_t        plan[$];
    int               sent;
    int               items;
    int               roll;
    logic [CFG_W-1:0] v;
    logic [TICK_W-1:0] t;
    logic signed [DELTA_W-1:0] d;

    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    pin_on = 1'b0;
    pin_want = '0;
    calm_tx = 1'b0;
    ticks_taken = 0;
    writes_taken = 0;
    mismatches = 0;
    foreach (mode_hits[m]) mode_hits[m] = 0;

    // Positions and speeds in the pinned rows follow from the rows above them.
    plan = '{
      // Coast after reset: elapsed zero, delta extremes, truncating division.
      tk_exp(16'sd0, 32'd0, 0, 0, 0, 1'b0, DRIVE_COAST),
      tk_exp(16'sd32767, 32'd1, 32767, 327670000, 0, 1'b0, DRIVE_COAST),
      tk_exp(-16'sd32768, 32'd1, -1, -327680000, 0, 1'b0, DRIVE_COAST),
      tk_exp(-16'sd32768, 32'hffff_ffff, -32769, 0, 0, 1'b0, DRIVE_COAST),
      tk_exp(16'sd7, 32'd3, -32762, 23333, 0, 1'b0, DRIVE_COAST),
      tk_exp(-16'sd7, 32'd3, -32769, -23333, 0, 1'b0, DRIVE_COAST),
      cw(REG_CONTROL_MODE, MODE_BRAKE),
      tk_exp(16'sd1, 32'd10000, -32768, 1, 0, 1'b0, DRIVE_BRAKE),
      // Manual pass-through at both duty extremes.
      cw(REG_CONTROL_MODE, MODE_MANUAL),
      cw(REG_MANUAL_DIRECTION, 32'd1),
      cw(REG_PWM_SETTING, DUTY_MAX),
      tk_exp(16'sd0, 32'd0, -32768, 0, 255, 1'b1, DRIVE_PWM),
      cw(REG_PWM_SETTING, 32'd0),
      cw(REG_MANUAL_DIRECTION, 32'd0),
      tk_exp(16'sd0, 32'd0, -32768, 0, 0, 1'b0, DRIVE_PWM),
      // Position control: saturation at 255, small error, sign flip.
      cw(REG_CONTROL_MODE, MODE_POSITION),
      cw(REG_PWM_SETTING, DUTY_MAX),
      cw(REG_GAIN_P, 32'd1),
      tk_exp(16'sd0, 32'd1, -32768, 0, 255, 1'b0, DRIVE_PWM),
      tk_exp(16'sd32767, 32'd1, -1, 327670000, 1, 1'b0, DRIVE_PWM),
      tk_exp(16'sd2, 32'd10000, 1, 2, 1, 1'b1, DRIVE_PWM),
      // Extreme gains and targets, clamped by the duty ceiling.
      cw(REG_GAIN_P, 32'hffff_8000),
      cw(REG_GAIN_D, 32'h0000_8000),
      cw(REG_TARGET_POSITION, 32'h7fff_ffff),
      cw(REG_PWM_SETTING, 32'd100),
      tk(16'sd1, 32'd0),
      cw(REG_GAIN_P, 32'h0000_7fff),
      cw(REG_GAIN_D, 32'h0000_7fff),
      cw(REG_TARGET_POSITION, 32'h8000_0000),
      tk(-16'sd32768, 32'hffff_ffff),
      // Zero PD sum drives forward at zero duty.
      cw(REG_GAIN_P, 32'd0),
      cw(REG_GAIN_D, 32'd0),
      tk_exp(16'sd5, 32'd7, -32761, 7142, 0, 1'b0, DRIVE_PWM),
      // Speed control: zero gain holds, large target saturates high, large speed low.
      cw(REG_CONTROL_MODE, MODE_SPEED),
      cw(REG_MANUAL_DIRECTION, 32'd1),
      tk_exp(16'sd0, 32'd0, -32761, 0, 0, 1'b1, DRIVE_PWM),
      cw(REG_GAIN_P, 32'd1),
      cw(REG_TARGET_SPEED, 32'h8000_0000),
      tk_exp(16'sd0, 32'd0, -32761, 0, 255, 1'b1, DRIVE_PWM),
      cw(REG_TARGET_SPEED, 32'd0),
      tk_exp(16'sd32767, 32'd1, 6, 327670000, 0, 1'b1, DRIVE_PWM),
      cw(REG_GAIN_P, 32'h0000_ffff),
      cw(REG_MANUAL_DIRECTION, 32'd0),
      tk_exp(16'sd100, 32'd10000, 106, 100, 100, 1'b0, DRIVE_PWM),
      cw(REG_GAIN_P, 32'd3),
      cw(REG_TARGET_SPEED, 32'd10),
      tk(-16'sd1, 32'd10000),
      cw(REG_GAIN_P, 32'hffff_fff9),
      cw(REG_TARGET_SPEED, 32'hffff_ffec),
      tk(16'sd0, 32'd0),
      // Unused mode codes coast; the unused register index changes nothing.
      cw(REG_CONTROL_MODE, {29'h1fff_ffff, MODE_UNUSED_HI}),
      tk_exp(16'sd3, 32'd3, 108, 10000, 0, 1'b0, DRIVE_COAST),
      cw(REG_CONTROL_MODE, MODE_UNUSED_LO),
      cw(REG_UNUSED, 32'hdead_beef),
      tk_exp(-16'sd3, 32'd0, 105, -30000, 0, 1'b0, DRIVE_COAST)
    };

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Walk the table; registers change only once the controller has drained.
    foreach (plan[r]) begin
      if (plan[r].is_write) begin
        wait_idle();
        write_reg(plan[r].idx, plan[r].value);
      end else begin
        send_tick(plan[r].delta, plan[r].ticks, plan[r].pinned, plan[r].want);
      end
    end

    // Random phases: reprogram every register, then run a burst of ticks.
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      wait_idle();

      roll = $urandom_range(0, 99);
      if (roll < 30) v = MODE_POSITION;
      else if (roll < 60) v = MODE_SPEED;
      else if (roll < 72) v = MODE_MANUAL;
      else if (roll < 82) v = MODE_FLOAT;
      else if (roll < 90) v = MODE_BRAKE;
      else v = $urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI);
      write_reg(REG_CONTROL_MODE, with_junk(v, MODE_W));

      write_reg(REG_MANUAL_DIRECTION, with_junk($urandom_range(0, 1), 1));

      roll = $urandom_range(0, 99);
      if (roll < 25) v = DUTY_MAX;
      else if (roll < 35) v = '0;
      else v = $urandom_range(0, 255);
      write_reg(REG_PWM_SETTING, with_junk(v, DUTY_W));

      // Aim near the present position so the PD loop spends time off its rails.
      roll = $urandom_range(0, 99);
      if (roll < 8) v = 32'h7fff_ffff;
      else if (roll < 15) v = 32'h8000_0000;
      else v = odometer + (int'($urandom_range(0, 6000)) - 3000);
      write_reg(REG_TARGET_POSITION, v);

      roll = $urandom_range(0, 99);
      if (roll < 10) v = 32'h8000_0000;
      else if (roll < 18) v = 32'h7fff_ffff;
      else if (roll < 28) v = $urandom;
      else v = int'($urandom_range(0, 120000)) - 60000;
      write_reg(REG_TARGET_SPEED, v);

      roll = $urandom_range(0, 99);
      if (roll < 6) v = 32'h0000_8000;
      else if (roll < 12) v = 32'h0000_7fff;
      else if (roll < 22) v = '0;
      else if (roll < 35) v = $urandom;
      else v = int'($urandom_range(0, 128)) - 64;
      write_reg(REG_GAIN_P, with_junk(v, GAIN_W));

      roll = $urandom_range(0, 99);
      if (roll < 8) v = 32'h0000_8000;
      else if (roll < 16) v = 32'h0000_7fff;
      else if (roll < 40) v = '0;
      else if (roll < 50) v = $urandom;
      else v = int'($urandom_range(0, 8)) - 4;
      write_reg(REG_GAIN_D, with_junk(v, GAIN_W));

      if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, $urandom);

      // Some bursts run back to back with no sender gaps at all.
      calm_tx = ($urandom_range(0, 3) == 0);
      items = $urandom_range(15, 50);
      repeat (items) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) v = 32'h0000_7fff;
        else if (roll < 10) v = 32'h0000_8000;
        else if (roll < 25) v = $urandom;
        else v = int'($urandom_range(0, 80)) - 40;
        d = v[DELTA_W-1:0];
        roll = $urandom_range(0, 99);
        if (roll < 10) t = '0;
        else if (roll < 15) t = '1;
        else if (roll < 25) t = $urandom;
        else t = $urandom_range(1, 30000);
        send_tick(d, t, 1'b0, '0);
        sent++;
      end
    end

    // Drain, then idle long enough for any stray result to show up.
    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("summary: %0d ticks checked over %0d register writes", ticks_taken,
             writes_taken);
    $display("summary: ticks per mode float %0d brake %0d manual %0d position %0d speed %0d",
             mode_hits[MODE_FLOAT], mode_hits[MODE_BRAKE], mode_hits[MODE_MANUAL],
             mode_hits[MODE_POSITION], mode_hits[MODE_SPEED]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
